@@ rtl/core/lamport_request_priority_queue_defines.svh @@
// ----------------------------------------------------------------------------
// Lamport request priority queue assertion macros
// Concurrent assertion helpers used by the RTL of the request queue.
// ----------------------------------------------------------------------------
`ifndef LAMPORT_REQUEST_PRIORITY_QUEUE_DEFINES_SVH
`define LAMPORT_REQUEST_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define LRPQ_ASSERT_IMPL(LABEL, CLK, RSTN, ANTE, CONS) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error("lamport_request_priority_queue: assertion failed");
// Next-cycle implication, checked outside reset.
`define LRPQ_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error("lamport_request_priority_queue: assertion failed");
`else
`define LRPQ_ASSERT_IMPL(LABEL, CLK, RSTN, ANTE, CONS)
`define LRPQ_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS)
`endif

`endif

@@ rtl/core/lrpq_pkg.sv @@
// ----------------------------------------------------------------------------
// Lamport request priority queue package
// Action and status codes and the approval counter format.
// ----------------------------------------------------------------------------
package lrpq_pkg;

    localparam int APPR_BITS = 4;
    localparam logic [APPR_BITS-1:0] APPR_MAX = '1;

    typedef logic [1:0] action_t;
    typedef logic [1:0] status_t;

    localparam action_t ACT_PUSH    = 2'd0;
    localparam action_t ACT_POP     = 2'd1;
    localparam action_t ACT_REFRESH = 2'd2;
    localparam action_t ACT_NOP     = 2'd3;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

endpackage

@@ rtl/core/lamport_request_priority_queue.sv @@
// ----------------------------------------------------------------------------
// Lamport request priority queue
// Sorted request store with saturating approval counts, walked through a RAM.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand over one word (push, pop, refresh or
// no operation). Exactly one result word follows, shown for a single cycle
// with done high; it cannot be held off, so the receiver must take it then.
// A full push, an empty pop or refresh, a pop of the last entry, a push into
// an empty queue and a no operation answer in the cycle after start. Other
// actions walk the entry RAM one entry per cycle through its one read port
// and one write port: a push from the tail down to its slot, a pop over the
// entries behind the head and a refresh over all entries. busy stays high
// until the result word appears.
// ----------------------------------------------------------------------------
`include "lamport_request_priority_queue_defines.svh"

module lamport_request_priority_queue
    import lrpq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int STAMP_BITS = 15,
    parameter int ID_BITS    = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   action,
    input  logic [STAMP_BITS-1:0]        stamp,
    input  logic [ID_BITS-1:0]           proc_id,
    output logic                         done,
    output logic [1:0]                   status,
    output logic                         head_valid,
    output logic [STAMP_BITS-1:0]        head_stamp,
    output logic [ID_BITS-1:0]           head_proc,
    output logic [APPR_BITS-1:0]         head_approvals,
    output logic [$clog2(DEPTH+1)-1:0]   occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = STAMP_BITS + ID_BITS + APPR_BITS;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_INSERT = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]            state_reg, state_next;
    action_t               op_reg, op_next;
    logic [STAMP_BITS-1:0] key_stamp_reg, key_stamp_next;
    logic [ID_BITS-1:0]    key_proc_reg, key_proc_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [STAMP_BITS-1:0] head_stamp_reg, head_stamp_next;
    logic [ID_BITS-1:0]    head_proc_reg, head_proc_next;
    logic [APPR_BITS-1:0]  head_appr_reg, head_appr_next;
    logic                  issue_reg, issue_next;
    logic [AW-1:0]         rd_idx_reg, rd_idx_next;
    logic [AW-1:0]         end_idx_reg, end_idx_next;
    logic                  dv_reg, dv_next;
    logic [AW-1:0]         d_idx_reg, d_idx_next;
    logic                  done_reg, done_next;
    status_t               status_reg, status_next;
    logic                  hv_reg, hv_next;
    logic [STAMP_BITS-1:0] hs_reg, hs_next;
    logic [ID_BITS-1:0]    hp_reg, hp_next;
    logic [APPR_BITS-1:0]  ha_reg, ha_next;
    logic [CW-1:0]         occ_reg, occ_next;

    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [EW-1:0]         ram_wr_data;
    logic                  ram_rd_en;
    logic [AW-1:0]         ram_rd_addr;
    logic [EW-1:0]         ram_rd_data;

    logic [STAMP_BITS-1:0] rd_stamp;
    logic [ID_BITS-1:0]    rd_proc;
    logic [APPR_BITS-1:0]  rd_appr;
    logic [APPR_BITS-1:0]  upd_appr;
    logic                  rd_less;
    logic                  is_full;
    logic                  is_empty;

    lrpq_ram #(
        .WIDTH(EW),
        .DEPTH(DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_stamp = ram_rd_data[EW-1 -: STAMP_BITS];
    assign rd_proc  = ram_rd_data[APPR_BITS +: ID_BITS];
    assign rd_appr  = ram_rd_data[APPR_BITS-1:0];

    // Entry key strictly below the new request: the request goes behind it.
    assign rd_less = (rd_stamp < key_stamp_reg) ||
                     ((rd_stamp == key_stamp_reg) && (rd_proc < key_proc_reg));

    assign upd_appr = ((rd_proc != key_proc_reg) && (rd_stamp < key_stamp_reg) &&
                       (rd_appr != APPR_MAX)) ? rd_appr + 1'b1 : rd_appr;

    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_stamp_next  = key_stamp_reg;
        key_proc_next   = key_proc_reg;
        count_next      = count_reg;
        head_stamp_next = head_stamp_reg;
        head_proc_next  = head_proc_reg;
        head_appr_next  = head_appr_reg;
        issue_next      = issue_reg;
        rd_idx_next     = rd_idx_reg;
        end_idx_next    = end_idx_reg;
        dv_next         = 1'b0;
        d_idx_next      = d_idx_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        hv_next         = hv_reg;
        hs_next         = hs_reg;
        hp_next         = hp_reg;
        ha_next         = ha_reg;
        occ_next        = occ_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = '0;
        ram_wr_data     = '0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = rd_idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next        = action;
                    key_stamp_next = stamp;
                    key_proc_next  = proc_id;
                    // Default answer: current head, unchanged queue.
                    status_next    = STATUS_OK;
                    hv_next        = !is_empty;
                    hs_next        = is_empty ? '0 : head_stamp_reg;
                    hp_next        = is_empty ? '0 : head_proc_reg;
                    ha_next        = is_empty ? '0 : head_appr_reg;
                    occ_next       = count_reg;
                    case (action)
                        ACT_PUSH:
                        begin
                            if (is_full)
                            begin
                                status_next = STATUS_FULL;
                                done_next   = 1'b1;
                            end
                            else if (is_empty)
                            begin
                                ram_wr_en       = 1'b1;
                                ram_wr_addr     = '0;
                                ram_wr_data     = {stamp, proc_id, {APPR_BITS{1'b0}}};
                                head_stamp_next = stamp;
                                head_proc_next  = proc_id;
                                head_appr_next  = '0;
                                count_next      = CW'(1);
                                hv_next         = 1'b1;
                                hs_next         = stamp;
                                hp_next         = proc_id;
                                ha_next         = '0;
                                occ_next        = CW'(1);
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                count_next   = count_reg + 1'b1;
                                issue_next   = 1'b1;
                                rd_idx_next  = AW'(count_reg - 1'b1);
                                end_idx_next = '0;
                                state_next   = ST_WALK;
                            end
                        end
                        ACT_POP:
                        begin
                            if (is_empty)
                            begin
                                status_next = STATUS_EMPTY;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                // The popped entry is the result; shadowed head.
                                count_next = count_reg - 1'b1;
                                occ_next   = count_reg - 1'b1;
                                if (count_reg == CW'(1))
                                begin
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    issue_next   = 1'b1;
                                    rd_idx_next  = AW'(1);
                                    end_idx_next = AW'(count_reg - 1'b1);
                                    state_next   = ST_WALK;
                                end
                            end
                        end
                        ACT_REFRESH:
                        begin
                            if (is_empty)
                            begin
                                status_next = STATUS_EMPTY;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                issue_next   = 1'b1;
                                rd_idx_next  = '0;
                                end_idx_next = AW'(count_reg - 1'b1);
                                state_next   = ST_WALK;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (issue_reg)
                begin
                    ram_rd_en  = 1'b1;
                    dv_next    = 1'b1;
                    d_idx_next = rd_idx_reg;
                    if (rd_idx_reg == end_idx_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else if (op_reg == ACT_PUSH)
                    begin
                        rd_idx_next = rd_idx_reg - 1'b1;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end
                if (dv_reg)
                begin
                    ram_wr_en = 1'b1;
                    case (op_reg)
                        ACT_PUSH:
                        begin
                            // Walking down from the tail; every write lands one
                            // above the entry just read, clear of the next read.
                            ram_wr_addr = d_idx_reg + 1'b1;
                            if (rd_less)
                            begin
                                ram_wr_data = {key_stamp_reg, key_proc_reg,
                                               {APPR_BITS{1'b0}}};
                                issue_next  = 1'b0;
                                dv_next     = 1'b0;
                                state_next  = ST_FINISH;
                            end
                            else
                            begin
                                ram_wr_data = ram_rd_data;
                                if (d_idx_reg == '0)
                                begin
                                    state_next = ST_INSERT;
                                end
                            end
                        end
                        ACT_POP:
                        begin
                            ram_wr_addr = d_idx_reg - 1'b1;
                            ram_wr_data = ram_rd_data;
                            if (d_idx_reg == AW'(1))
                            begin
                                head_stamp_next = rd_stamp;
                                head_proc_next  = rd_proc;
                                head_appr_next  = rd_appr;
                            end
                            if (d_idx_reg == end_idx_reg)
                            begin
                                state_next = ST_FINISH;
                            end
                        end
                        default:
                        begin
                            ram_wr_addr = d_idx_reg;
                            ram_wr_data = {rd_stamp, rd_proc, upd_appr};
                            if (d_idx_reg == '0)
                            begin
                                head_appr_next = upd_appr;
                            end
                            if (d_idx_reg == end_idx_reg)
                            begin
                                state_next = ST_FINISH;
                            end
                        end
                    endcase
                end
            end
            ST_INSERT:
            begin
                ram_wr_en       = 1'b1;
                ram_wr_addr     = '0;
                ram_wr_data     = {key_stamp_reg, key_proc_reg, {APPR_BITS{1'b0}}};
                head_stamp_next = key_stamp_reg;
                head_proc_next  = key_proc_reg;
                head_appr_next  = '0;
                state_next      = ST_FINISH;
            end
            ST_FINISH:
            begin
                done_next  = 1'b1;
                occ_next   = count_reg;
                state_next = ST_IDLE;
                if (op_reg != ACT_POP)
                begin
                    status_next = STATUS_OK;
                    hv_next     = !is_empty;
                    hs_next     = is_empty ? '0 : head_stamp_reg;
                    hp_next     = is_empty ? '0 : head_proc_reg;
                    ha_next     = is_empty ? '0 : head_appr_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            issue_reg <= 1'b0;
            dv_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            issue_reg <= issue_next;
            dv_reg    <= dv_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_stamp_reg  <= key_stamp_next;
        key_proc_reg   <= key_proc_next;
        head_stamp_reg <= head_stamp_next;
        head_proc_reg  <= head_proc_next;
        head_appr_reg  <= head_appr_next;
        rd_idx_reg     <= rd_idx_next;
        end_idx_reg    <= end_idx_next;
        d_idx_reg      <= d_idx_next;
        status_reg     <= status_next;
        hv_reg         <= hv_next;
        hs_reg         <= hs_next;
        hp_reg         <= hp_next;
        ha_reg         <= ha_next;
        occ_reg        <= occ_next;
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign head_valid     = hv_reg;
    assign head_stamp     = hs_reg;
    assign head_proc      = hp_reg;
    assign head_approvals = ha_reg;
    assign occupancy      = occ_reg;

    `LRPQ_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH))
    `LRPQ_ASSERT_IMPL(a_done_when_idle, clk, rst_n, done_reg, state_reg == ST_IDLE)
    `LRPQ_ASSERT_IMPL(a_no_port_collision, clk, rst_n, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr)
    `LRPQ_ASSERT_NEXT(a_start_answered, clk, rst_n, start && !busy, busy || done_reg)
    `LRPQ_ASSERT_IMPL(a_idle_no_reads, clk, rst_n, state_reg == ST_IDLE, !ram_rd_en && !dv_reg)

endmodule

@@ rtl/core/lrpq_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lrpq_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
